/* src/sliding_window_median_filter_defines.svh */
// ----------------------------------------------------------------------------
// sliding window median filter assertion macros
// shared property wrappers, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_DEFINES_SVH

// same-cycle implication
`define SWMF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SWMF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/swmf_pkg.sv */
// ----------------------------------------------------------------------------
// swmf_pkg
// sequencer states and control bundle of the sliding window median filter
// ----------------------------------------------------------------------------
package swmf_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// control from the sequencer to the datapath
	typedef struct packed {
		logic idle;    // ready for a new request
		logic take;    // request accepted this cycle
		logic rotate;  // scan step: rotate window, feed comparators
		logic load;    // move final pick into the output register
	} ctl_t;

endpackage

/* src/swmf_window.sv */
// ----------------------------------------------------------------------------
// swmf_window
// ring window of samples; writes at the write pointer, rotates while scanning
// ----------------------------------------------------------------------------
module swmf_window #(
	parameter int WINDOW_SIZE = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swmf_pkg::ctl_t                ctl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic signed [SAMPLE_BITS-1:0] win [WINDOW_SIZE]
);
	import swmf_pkg::*;

	localparam int PTR_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_SIZE - 1);

	logic signed [SAMPLE_BITS-1:0] win_q [WINDOW_SIZE];
	logic [PTR_W-1:0]              wr_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q <= '0;
		end else if (ctl.take) begin
			wr_pos_q <= (wr_pos_q == PTR_LAST) ? '0 : wr_pos_q + PTR_W'(1);
		end
	end

	// a full turn of N rotations brings every slot back home
	for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_slot
		localparam int NEXT = (i + 1) % WINDOW_SIZE;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				win_q[i] <= '0;
			end else if (ctl.take && (wr_pos_q == PTR_W'(i))) begin
				win_q[i] <= sample;
			end else if (ctl.rotate) begin
				win_q[i] <= win_q[NEXT];
			end
		end
		assign win[i] = win_q[i];
	end

endmodule

/* src/swmf_rank.sv */
// ----------------------------------------------------------------------------
// swmf_rank
// shared rank unit: compares slot 0 against every slot, then counts balance
// ----------------------------------------------------------------------------
module swmf_rank #(
	parameter int WINDOW_SIZE = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  swmf_pkg::ctl_t                           ctl,
	input  logic signed [SAMPLE_BITS-1:0]            win [WINDOW_SIZE],
	output logic                                     busy_s1,
	output logic                                     vld_s2,
	output logic signed [SAMPLE_BITS-1:0]            cand_s2,
	output logic [$clog2(WINDOW_SIZE+1)-1:0]         abs_bal
);
	import swmf_pkg::*;

	localparam int BAL_W = $clog2(WINDOW_SIZE + 1);

	logic [WINDOW_SIZE-1:0]        gt_s1;
	logic [WINDOW_SIZE-1:0]        lt_s1;
	logic signed [SAMPLE_BITS-1:0] cand_s1;
	logic                          vld_s1;
	logic [BAL_W-1:0]              gt_cnt_s2;
	logic [BAL_W-1:0]              lt_cnt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= ctl.rotate;
			vld_s2 <= vld_s1;
		end
	end

	// stage 1: one candidate against all slots
	always_ff @(posedge clk) begin
		cand_s1 <= win[0];
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			gt_s1[i] <= win[i] > win[0];
			lt_s1[i] <= win[i] < win[0];
		end
	end

	// stage 2: population counts
	always_ff @(posedge clk) begin
		cand_s2   <= cand_s1;
		gt_cnt_s2 <= BAL_W'($countones(gt_s1));
		lt_cnt_s2 <= BAL_W'($countones(lt_s1));
	end

	assign abs_bal = (gt_cnt_s2 >= lt_cnt_s2) ? gt_cnt_s2 - lt_cnt_s2
	                                          : lt_cnt_s2 - gt_cnt_s2;
	assign busy_s1 = vld_s1;

endmodule

/* src/swmf_seq.sv */
// ----------------------------------------------------------------------------
// swmf_seq
// sequencer: accept, scan every slot, drain the rank pipe, hand off result
// ----------------------------------------------------------------------------
module swmf_seq #(
	parameter int WINDOW_SIZE = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           sample_valid,
	input  logic           out_full,
	input  logic           pipe_busy,
	output swmf_pkg::ctl_t ctl
);
	import swmf_pkg::*;

	localparam int CNT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_SIZE - 1);

	state_t           state_q;
	state_t           state_nxt;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (ctl.take) begin
				cnt_q <= '0;
			end else if (ctl.rotate) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (sample_valid) state_nxt = ST_SCAN;
			ST_SCAN:  if (cnt_q == CNT_LAST) state_nxt = ST_DRAIN;
			ST_DRAIN: if (!pipe_busy) state_nxt = ST_DONE;
			ST_DONE:  if (!out_full) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctl.idle = 1'b1;
				ctl.take = sample_valid;
			end
			ST_SCAN:  ctl.rotate = 1'b1;
			ST_DRAIN: ctl = '0;
			ST_DONE:  ctl.load = !out_full;
			default:  ctl = '0;
		endcase
	end

endmodule

/* src/sliding_window_median_filter.sv */
// ----------------------------------------------------------------------------
// sliding_window_median_filter
// running median over the last WINDOW_SIZE signed samples
// ----------------------------------------------------------------------------
// Each sample request is written into a ring window at the write pointer
// (window and pointer clear to zero at reset, so early results rank the reset
// zeros too). The block then scans the slots in storage order, one candidate
// per cycle: the window rotates by one slot each scan cycle, slot 0 feeds a
// bank of WINDOW_SIZE comparators, and two pipeline stages turn the compare
// vectors into the absolute rank balance |greater - smaller|. The first slot
// with the smallest balance wins, so ties go to the lowest storage index.
// Each sample goes through an accept, a scan of every slot through the single
// comparator bank, a drain of the rank pipe and a hand-off; the block takes no
// new sample before the hand-off returns it to idle. The result sits in an
// output register; a new sample may be accepted while it waits, and the
// following result is held back until the previous one is taken.
module sliding_window_median_filter #(
	parameter int WINDOW_SIZE = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          median_valid,
	input  logic                          median_ready,
	output logic signed [SAMPLE_BITS-1:0] median
);
	import swmf_pkg::*;

	localparam int BAL_W = $clog2(WINDOW_SIZE + 1);

	ctl_t                          ctl;
	logic signed [SAMPLE_BITS-1:0] win [WINDOW_SIZE];
	logic                          busy_s1;
	logic                          vld_s2;
	logic signed [SAMPLE_BITS-1:0] cand_s2;
	logic [BAL_W-1:0]              abs_bal;
	logic [BAL_W-1:0]              best_bal_q;   // smallest balance seen so far
	logic signed [SAMPLE_BITS-1:0] best_val_q;   // value of that slot
	logic signed [SAMPLE_BITS-1:0] median_q;
	logic                          median_valid_q;
	logic                          out_full;

	// output register still holds a result nobody has taken
	assign out_full = median_valid_q && !median_ready;

	swmf_seq #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.out_full    (out_full),
		.pipe_busy   (busy_s1),
		.ctl         (ctl)
	);

	swmf_window #(
		.WINDOW_SIZE(WINDOW_SIZE),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.sample(sample),
		.win   (win)
	);

	swmf_rank #(
		.WINDOW_SIZE(WINDOW_SIZE),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.win    (win),
		.busy_s1(busy_s1),
		.vld_s2 (vld_s2),
		.cand_s2(cand_s2),
		.abs_bal(abs_bal)
	);

	// best-so-far tracking; strict less-than keeps the earliest slot on ties.
	// every balance is at most WINDOW_SIZE - 1, so the first candidate always wins
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			best_bal_q <= BAL_W'(WINDOW_SIZE);
		end else if (vld_s2 && (abs_bal < best_bal_q)) begin
			best_bal_q <= abs_bal;
			best_val_q <= cand_s2;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			median_valid_q <= 1'b0;
		end else if (ctl.load) begin
			median_valid_q <= 1'b1;
		end else if (median_ready) begin
			median_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			median_q <= best_val_q;
		end
	end

	assign sample_ready = ctl.idle;
	assign median_valid = median_valid_q;
	assign median       = median_q;

endmodule

/* src/swmf_checker.sv */
// ----------------------------------------------------------------------------
// swmf_checker
// port-level checks of the sliding window median filter, bound to the top
// ----------------------------------------------------------------------------
`include "sliding_window_median_filter_defines.svh"

module swmf_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          sample_valid,
	input logic                          sample_ready,
	input logic signed [SAMPLE_BITS-1:0] sample,
	input logic                          median_valid,
	input logic                          median_ready,
	input logic signed [SAMPLE_BITS-1:0] median
);

	// waiting request keeps valid and payload
	`SWMF_ASSERT_NEXT(a_in_hold, sample_valid && !sample_ready,
		sample_valid && $stable(sample), "sample changed while waiting")

	// stalled result keeps its value
	`SWMF_ASSERT_NEXT(a_out_hold, median_valid && !median_ready,
		median_valid && $stable(median), "median changed while stalled")

	// block is busy right after taking a request
	`SWMF_ASSERT_NEXT(a_busy_after_take, sample_valid && sample_ready,
		!sample_ready, "ready right after an accepted sample")

	// a new result appears just as the sequencer returns to idle
	`SWMF_ASSERT_NOW(a_result_at_idle, $rose(median_valid),
		sample_ready, "result shown while the block is busy")

endmodule

bind sliding_window_median_filter swmf_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_swmf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.sample_valid(sample_valid),
	.sample_ready(sample_ready),
	.sample      (sample),
	.median_valid(median_valid),
	.median_ready(median_ready),
	.median      (median)
);
